// ===== hdl/ilie_pkg.sv =====
// Shared types and codes for the indexed list insert/erase block.
package ilie_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [4:0]  index;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic [4:0]  count;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic ers;
    } t_cell_ctl;

endpackage

// ===== hdl/ilie_cell.sv =====
// One storage cell of the list row: holds one entry and shifts with its neighbors.
module ilie_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 5,
    parameter int POS        = 0
) (
    input  logic                     i_clk,
    input  ilie_pkg::t_cell_ctl      i_ctl,
    input  logic [IDX_W-1:0]         i_idx,
    input  logic [DATA_WIDTH-1:0]    i_value,
    input  logic [DATA_WIDTH-1:0]    i_lower,
    input  logic [DATA_WIDTH-1:0]    i_upper,
    output logic [DATA_WIDTH-1:0]    o_data
);

    localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(POS);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && (POS_IDX == i_idx)) begin
            n_data = i_value;
        end else if (i_ctl.ins && (POS_IDX > i_idx)) begin
            n_data = i_lower;
        end else if (i_ctl.ers && (POS_IDX >= i_idx)) begin
            n_data = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hdl/indexed_list_insert_erase.sv =====
// Top level of the indexed list: operation decode, cell row and result register.
//
// Usage: an ordered list of up to CAPACITY words held in a row of cells.
// Input channel i_in (i_in_valid / o_in_stall) carries one operation per
// transaction: append, insert at index, erase at index or read at index.
// Output channel o_out (o_out_valid / i_out_stall) returns one result per
// transaction: status, the word read (zero unless a read succeeds) and the
// entry count after the operation.
// The result is registered and presented in the cycle after its transaction is taken.
// Throughput: one transaction per cycle while o_in_stall is low; all affected cells
// shift or load in the same cycle, so insert and erase take no longer than a read.
// Reset (synchronous, active low on i_rst_n) empties the list and drops any
// pending result; stored words are not cleared and are never read before
// being written.
// When the receiver stalls, the result register holds and o_in_stall rises,
// so no new transaction is taken until the pending result leaves.
module indexed_list_insert_erase #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ilie_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ilie_pkg::t_out_item  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    ilie_pkg::t_out_item   r_out;

    logic                  w_accept;
    logic [CMP_W-1:0]      w_idx;
    logic [CMP_W-1:0]      w_cnt;
    logic [CMP_W-1:0]      w_cell_idx;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_rd;
    ilie_pkg::t_status     w_status;
    ilie_pkg::t_cell_ctl   w_ctl;
    ilie_pkg::t_out_item   w_res;
    logic [DATA_WIDTH-1:0] w_ext [0:CAPACITY+1];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_idx      = CMP_W'(i_in.index);
    assign w_cnt      = CMP_W'(r_count);
    assign w_value    = DATA_WIDTH'(i_in.value);

    always_comb begin
        w_status   = ilie_pkg::ST_OK;
        w_ctl      = '0;
        w_cell_idx = w_idx;
        n_count    = r_count;
        w_rd       = '0;
        case (i_in.op)
            ilie_pkg::OP_APPEND: begin
                w_cell_idx = w_cnt;
                if (w_cnt >= CAP_C) begin
                    w_status = ilie_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ilie_pkg::OP_INSERT: begin
                if (w_idx > w_cnt) begin
                    w_status = ilie_pkg::ST_BOUNDS;
                end else if (w_cnt >= CAP_C) begin
                    w_status = ilie_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ilie_pkg::OP_ERASE: begin
                if (w_idx >= w_cnt) begin
                    w_status = ilie_pkg::ST_BOUNDS;
                end else begin
                    w_ctl.ers = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            ilie_pkg::OP_READ: begin
                if (w_idx >= w_cnt) begin
                    w_status = ilie_pkg::ST_BOUNDS;
                end else begin
                    for (int i = 0; i < RD_N; i++) begin
                        if (w_idx == CMP_W'(i)) begin
                            w_rd = w_ext[i+1];
                        end
                    end
                end
            end
            default: begin
                w_status = ilie_pkg::ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_ctl   = '0;
            n_count = r_count;
        end
    end

    assign w_res.status     = w_status;
    assign w_res.read_value = 32'(w_rd);
    assign w_res.count      = 5'(n_count);

    assign w_ext[0]          = '0;
    assign w_ext[CAPACITY+1] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ilie_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (CMP_W),
            .POS        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (w_cell_idx),
            .i_value (w_value),
            .i_lower (w_ext[g]),
            .i_upper (w_ext[g+2]),
            .o_data  (w_ext[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CAP_C)
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.op == ilie_pkg::OP_APPEND && w_cnt < CAP_C)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not grow the list");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept) |=> (o_out.count == 5'(r_count)))
        else $error("result count differs from stored count");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ilie_pkg::ST_OK) |-> (o_out.read_value == '0))
        else $error("failed operation returned data");

endmodule
